[hw/rtl/sorted_rows_heap_merge_macros.svh]
// Assertion macros shared by the sorted-rows merge RTL.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef SORTED_ROWS_HEAP_MERGE_MACROS_SVH
`define SORTED_ROWS_HEAP_MERGE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every rising clock edge outside reset.
`define SRHM_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define SRHM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define SRHM_ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define SRHM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[hw/rtl/srhm_pkg.sv]
// Shared constants for the sorted-rows merge block.
// No dependencies; used by the RAM, the minimum tree and the top level.
package srhm_pkg;

  localparam int MAX_SIZE_DEF    = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the ports.
  localparam int DATA_W = 32;
  localparam int CFG_W  = 4;

  // Matrix size after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

endpackage

[hw/rtl/srhm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on srhm_pkg for default widths.
module srhm_ram #(
  parameter int WIDTH = srhm_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH = srhm_pkg::MAX_SIZE_DEF * srhm_pkg::MAX_SIZE_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/srhm_min_tree.sv]
// Registered comparison tree: smallest valid leaf and its index.
// One register level per tree level; ties go to the lower index.
// Depends on srhm_pkg for default widths.
module srhm_min_tree #(
  parameter int MAX_SIZE    = srhm_pkg::MAX_SIZE_DEF,
  parameter int VALUE_WIDTH = srhm_pkg::VALUE_WIDTH_DEF,
  parameter int RW          = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  logic                          clk,
  input  logic signed [VALUE_WIDTH-1:0] leaf_val [MAX_SIZE],
  input  logic        [MAX_SIZE-1:0]    leaf_vld,
  output logic signed [VALUE_WIDTH-1:0] root_val,
  output logic        [RW-1:0]          root_idx,
  output logic                          root_vld
);

  localparam int LV    = $clog2(MAX_SIZE);
  localparam int P     = 1 << LV;
  localparam int NODES = (P > 1) ? P - 1 : 1;

  logic signed [VALUE_WIDTH-1:0] pad_val [P];
  logic        [P-1:0]           pad_vld;

  // Heap-ordered nodes: node k (1-based) sits at k-1, children 2k and 2k+1.
  logic signed [VALUE_WIDTH-1:0] node_val [NODES];
  logic        [RW-1:0]          node_idx [NODES];
  logic        [NODES-1:0]       node_vld;

  for (genvar g = 0; g < P; g++) begin : g_pad
    if (g < MAX_SIZE) begin : g_real
      assign pad_val[g] = leaf_val[g];
      assign pad_vld[g] = leaf_vld[g];
    end else begin : g_fill
      assign pad_val[g] = '0;
      assign pad_vld[g] = 1'b0;
    end
  end

  if (P > 1) begin : g_tree
    for (genvar k = 1; k < P; k++) begin : g_node
      logic signed [VALUE_WIDTH-1:0] lval, rval;
      logic        [RW-1:0]          lidx, ridx;
      logic                          lvld, rvld, take_r;

      if (2 * k >= P) begin : g_leaf
        assign lval = pad_val[2*k-P];
        assign lidx = RW'(2*k-P);
        assign lvld = pad_vld[2*k-P];
        assign rval = pad_val[2*k+1-P];
        assign ridx = RW'(2*k+1-P);
        assign rvld = pad_vld[2*k+1-P];
      end else begin : g_inner
        assign lval = node_val[2*k-1];
        assign lidx = node_idx[2*k-1];
        assign lvld = node_vld[2*k-1];
        assign rval = node_val[2*k];
        assign ridx = node_idx[2*k];
        assign rvld = node_vld[2*k];
      end

      // Right wins only when strictly smaller, so equal heads keep the lower row.
      assign take_r = rvld && (!lvld || (rval < lval));

      always_ff @(posedge clk) begin
        node_val[k-1] <= take_r ? rval : lval;
        node_idx[k-1] <= take_r ? ridx : lidx;
        node_vld[k-1] <= take_r ? rvld : lvld;
      end
    end
  end else begin : g_single
    assign node_val[0] = pad_val[0];
    assign node_idx[0] = '0;
    assign node_vld[0] = pad_vld[0];
  end

  assign root_val = node_val[0];
  assign root_idx = node_idx[0];
  assign root_vld = node_vld[0];

endmodule

[hw/rtl/sorted_rows_heap_merge.sv]
// Sorted-rows k-way merge: top level, sequencer and output register.
// Depends on srhm_pkg, srhm_ram, srhm_min_tree and the assertion macro header.
//
//   channel   direction  handshake            payload
//   in        in         in_valid/in_ready    element_value
//   out       out        out_valid/out_ready  sorted_value, last_of_run
//   cfg       in         cfg_we               cfg_wdata (matrix_size)
//
// Loading takes one item a cycle outside a merge; the item that completes the n*n matrix starts a merge.
// Merge start reads each row head from the element RAM, a read then a write-back per row, then
// waits in the settle state for the registered minimum tree. Each result then steps through
// emit, RAM refill read and tree settle; a result that exhausts its row skips the refill read.
// No items are accepted while a merge runs. A stalled result holds in the output register,
// and the next item may be accepted while the final result of a merge still waits.
// Reset is synchronous; the element RAM needs no clearing, as every entry is written first.
`include "sorted_rows_heap_merge_macros.svh"

module sorted_rows_heap_merge #(
  parameter int MAX_SIZE    = srhm_pkg::MAX_SIZE_DEF,
  parameter int VALUE_WIDTH = srhm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration
  input  logic                              cfg_we,
  input  logic        [srhm_pkg::CFG_W-1:0] cfg_wdata,
  // Input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [srhm_pkg::DATA_W-1:0] element_value,
  // Result items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [srhm_pkg::DATA_W-1:0] sorted_value,
  output logic                              last_of_run
);

  localparam int LV    = $clog2(MAX_SIZE);               // tree levels
  localparam int RW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NW    = $clog2(MAX_SIZE + 1);           // holds n and a column pointer
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int SW    = (LV > 1) ? $clog2(LV) : 1;

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_FILL_RD = 6'b000010,
    S_FILL_WB = 6'b000100,
    S_SETTLE  = 6'b001000,
    S_EMIT    = 6'b010000,
    S_REFILL  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [srhm_pkg::CFG_W-1:0] cfg_size;

  logic [CNTW-1:0] load_cnt, load_cnt_inc, nsq_cur;
  logic [NW-1:0]   eff_n, merge_n;
  logic [RW-1:0]   fill_row, sel_row;
  logic [NW-1:0]   ptr [MAX_SIZE];
  logic [CNTW-1:0] out_left;
  logic [SW-1:0]   settle;

  logic signed [VALUE_WIDTH-1:0] head_val [MAX_SIZE];
  logic        [MAX_SIZE-1:0]    head_vld;

  logic signed [VALUE_WIDTH-1:0] root_val;
  logic        [RW-1:0]          root_idx;
  logic                          root_vld;

  logic                   in_fire, load_done, out_free, emit_go, row_end, go_settle;
  logic [NW-1:0]          root_ptr, root_ptr_inc;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  // ---------------------------------------------------------------------------
  // Size and load bookkeeping
  // ---------------------------------------------------------------------------

  // Size zero counts as one; sizes above MAX_SIZE saturate.
  always_comb begin
    if (cfg_size == '0) begin
      eff_n = NW'(1);
    end else if (cfg_size > srhm_pkg::CFG_W'(MAX_SIZE)) begin
      eff_n = NW'(MAX_SIZE);
    end else begin
      eff_n = NW'(cfg_size);
    end
  end

  assign nsq_cur      = CNTW'(eff_n) * CNTW'(eff_n);
  assign load_cnt_inc = load_cnt + CNTW'(1);

  assign in_ready  = (state == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  // A size change while loading can leave the count already past n*n: merge on the next item.
  assign load_done = in_fire && (load_cnt_inc >= nsq_cur);

  // ---------------------------------------------------------------------------
  // Merge datapath
  // ---------------------------------------------------------------------------

  assign out_free     = !out_valid || out_ready;
  assign emit_go      = (state == S_EMIT) && out_free;
  assign root_ptr     = ptr[root_idx];
  assign root_ptr_inc = root_ptr + NW'(1);
  assign row_end      = (root_ptr_inc == merge_n);
  // Tree depth zero skips the settle state.
  assign go_settle    = (LV > 0);

  // Fill reads the head of each row; refill reads the column after the one just emitted.
  always_comb begin
    if (state == S_FILL_RD) begin
      rd_addr = AW'(fill_row) * AW'(merge_n);
    end else begin
      rd_addr = AW'(root_idx) * AW'(merge_n) + AW'(root_ptr_inc);
    end
  end

  srhm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_cnt[AW-1:0]),
    .wdata (VALUE_WIDTH'(element_value)),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  srhm_min_tree #(
    .MAX_SIZE    (MAX_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH),
    .RW          (RW)
  ) u_tree (
    .clk      (clk),
    .leaf_val (head_val),
    .leaf_vld (head_vld),
    .root_val (root_val),
    .root_idx (root_idx),
    .root_vld (root_vld)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (load_done) begin
          state_next = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        state_next = S_FILL_WB;
      end
      S_FILL_WB: begin
        if (fill_row == RW'(merge_n - NW'(1))) begin
          state_next = go_settle ? S_SETTLE : S_EMIT;
        end else begin
          state_next = S_FILL_RD;
        end
      end
      S_SETTLE: begin
        if (settle == '0) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          if (out_left == CNTW'(1)) begin
            state_next = S_LOAD;
          end else if (row_end) begin
            state_next = go_settle ? S_SETTLE : S_EMIT;
          end else begin
            state_next = S_REFILL;
          end
        end
      end
      S_REFILL: begin
        state_next = go_settle ? S_SETTLE : S_EMIT;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cfg_size  <= srhm_pkg::CFG_RESET;
      load_cnt  <= '0;
      out_left  <= '0;
      head_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        cfg_size <= cfg_wdata;
      end

      // Advance the load count; wrap to zero when a merge starts.
      if (in_fire) begin
        load_cnt <= load_done ? '0 : load_cnt_inc;
      end

      if (load_done) begin
        out_left <= nsq_cur;
        head_vld <= '0;
      end else if (state == S_FILL_WB) begin
        head_vld[fill_row] <= 1'b1;
      end else if (emit_go) begin
        out_left <= out_left - CNTW'(1);
        // Drop an exhausted row from the tree.
        if (row_end) begin
          head_vld[root_idx] <= 1'b0;
        end
      end

      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load_done) begin
      merge_n  <= eff_n;
      fill_row <= '0;
      for (int r = 0; r < MAX_SIZE; r++) begin
        ptr[r] <= '0;
      end
    end

    if (state == S_FILL_WB) begin
      head_val[fill_row] <= rd_data;
      fill_row           <= fill_row + RW'(1);
    end

    if (state == S_REFILL) begin
      head_val[sel_row] <= rd_data;
    end

    // Restart the settle count after any head change.
    if (state_next == S_SETTLE && state != S_SETTLE) begin
      settle <= SW'(LV - 1);
    end else if (state == S_SETTLE) begin
      settle <= settle - SW'(1);
    end

    if (emit_go) begin
      ptr[root_idx] <= root_ptr_inc;
      sel_row       <= root_idx;
      sorted_value  <= srhm_pkg::DATA_W'(root_val);
      last_of_run   <= (out_left == CNTW'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  `SRHM_ASSERT_ALWAYS(a_load_cnt_range, clk, rst, load_cnt < CNTW'(DEPTH), "load count past store depth")
  `SRHM_ASSERT_IMPLY(a_emit_root, clk, rst, state == S_EMIT, root_vld && (root_idx < RW'(MAX_SIZE - 1) || root_idx == RW'(MAX_SIZE - 1)), "emit without a valid row head")
  `SRHM_ASSERT_IMPLY(a_emit_left, clk, rst, state == S_EMIT, out_left != '0, "emit with no results left")
  `SRHM_ASSERT_IMPLY(a_idle_clean, clk, rst, state == S_LOAD, head_vld == '0 && out_left == '0, "rows left over after a merge")

endmodule

[tb/tb.sv]
// Self-checking testbench for sorted_rows_heap_merge: matrices of signed elements go in,
// and each run that comes out is checked against a predicted merge.
// Depends on srhm_pkg and the sorted_rows_heap_merge RTL.
`timescale 1ns / 100ps

typedef struct packed {
  logic signed [srhm_pkg::DATA_W-1:0] value;
  logic                               last;
} merged_item_t;

class merge_scoreboard;
  logic [srhm_pkg::CFG_W-1:0]         size_code;
  logic signed [srhm_pkg::DATA_W-1:0] element_store [64];
  logic [6:0]                         load_count;
  merged_item_t                       expected [$];
  int                                 errors;

  function new();
    size_code  = srhm_pkg::CFG_RESET;
    load_count = '0;
    errors     = 0;
  endfunction

  function int span();
    int n;
    n = int'(size_code);
    if (n == 0) n = 1;
    if (n > srhm_pkg::MAX_SIZE_DEF) n = srhm_pkg::MAX_SIZE_DEF;
    return n;
  endfunction

  function int pending();
    return expected.size();
  endfunction

  // Repeatedly take the smallest live row head; ties go to the lower row.
  function void merge_rows(int n);
    logic [3:0]                         column [8];
    int                                 pool [8];
    int                                 pool_count, best, best_row, row, i, k;
    logic signed [srhm_pkg::DATA_W-1:0] best_value, head;
    merged_item_t                       item;
    pool_count = n;
    for (row = 0; row < n; row++) begin
      column[row] = '0;
      pool[row]   = row;
    end
    for (k = 0; k < n * n && pool_count > 0; k++) begin
      best       = 0;
      best_row   = pool[0];
      best_value = element_store[(best_row * n + column[best_row]) & 63];
      for (i = 1; i < pool_count; i++) begin
        row  = pool[i];
        head = element_store[(row * n + column[row]) & 63];
        if (head < best_value || (head == best_value && row < best_row)) begin
          best       = i;
          best_row   = row;
          best_value = head;
        end
      end
      item.value = best_value;
      item.last  = (k + 1 == n * n);
      expected.insert(expected.size(), item);
      column[best_row] = column[best_row] + 4'd1;
      if (column[best_row] >= n) begin
        for (i = best; i + 1 < pool_count; i++) pool[i] = pool[i + 1];
        pool_count--;
      end
    end
  endfunction

  function void note_element(logic signed [srhm_pkg::DATA_W-1:0] value);
    int n;
    n = span();
    element_store[load_count[5:0]] = value;
    load_count = load_count + 7'd1;
    if (load_count >= n * n) begin
      load_count = '0;
      merge_rows(n);
    end
  endfunction

  function void check_result(logic signed [srhm_pkg::DATA_W-1:0] value, logic last);
    merged_item_t want;
    if (expected.size() == 0) begin
      errors++;
      $display("%0t: unexpected result %0d last_of_run %0b", $time, value, last);
      return;
    end
    want = expected.pop_front();
    if (value !== want.value) begin
      errors++;
      $display("%0t: sorted_value expected %0d got %0d", $time, want.value, value);
    end
    if (last !== want.last) begin
      errors++;
      $display("%0t: last_of_run expected %0b got %0b", $time, want.last, last);
    end
  endfunction
endclass

module tb;

  localparam int RANDOM_ITEMS   = 480;
  localparam int SETTLE_CYCLES  = 40;    // well past the row-head fill and tree settle of a merge start
  localparam int HOLD_CYCLES    = 300;   // long receiver stall, enough to back up the input
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving on either side

  typedef enum int {ROWS_SORTED, ROWS_UNSORTED, PARTIAL_LOAD} matrix_kind_t;
  typedef enum int {WIDE, NARROW, EDGES} value_style_t;

  logic                               clk;
  logic                               rst;
  logic                               cfg_we;
  logic [srhm_pkg::CFG_W-1:0]         cfg_wdata;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [srhm_pkg::DATA_W-1:0] element_value;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [srhm_pkg::DATA_W-1:0] sorted_value;
  logic                               last_of_run;

  merge_scoreboard book;
  int              elements_sent = 0;
  int              idle_cycles = 0;
  bit              offer_burst = 0;   // sender runs back to back while set
  bit              ready_burst = 0;   // receiver stalls only on a hold request while set
  bit              hold_request = 0;  // ask the receiver for one long stall

  sorted_rows_heap_merge dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .element_value(element_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item after a random gap; hold valid and payload until the block takes it.
  // Valid is left high on return, so back-to-back items never drop it.
  task automatic send_item(input logic signed [srhm_pkg::DATA_W-1:0] value);
    int gap;
    gap = offer_burst ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 29) == 0) offer_burst = !offer_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    book.note_element(value);
    elements_sent++;
  endtask

  // Drop valid, wait for every predicted result, then let any merge start wind down.
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only while the block is idle.
  task automatic write_matrix_size(input logic [srhm_pkg::CFG_W-1:0] code);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.size_code = code;
  endtask

  function automatic logic signed [srhm_pkg::DATA_W-1:0] draw_value(value_style_t style);
    case (style)
      NARROW: return $urandom_range(0, 8) - 4;  // crowd values together so heads tie
      EDGES: begin
        case ($urandom_range(0, 4))
          0:       return {1'b1, {(srhm_pkg::DATA_W-1){1'b0}}};
          1:       return {1'b0, {(srhm_pkg::DATA_W-1){1'b1}}};
          2:       return '0;
          3:       return '1;
          default: return 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // One matrix at the current size: row by row, each row sorted unless asked otherwise.
  // A partial load stops short so that the next size write lands mid-matrix.
  task automatic send_matrix(input matrix_kind_t kind, input value_style_t style);
    logic signed [srhm_pkg::DATA_W-1:0] row [8];
    logic signed [srhm_pkg::DATA_W-1:0] key;
    int                                 n, r, c, j, count;
    n = book.span();
    if (kind == PARTIAL_LOAD) begin
      count = (n > 1) ? $urandom_range(1, n * n - 1) : 0;
      repeat (count) send_item(draw_value(style));
    end else begin
      for (r = 0; r < n; r++) begin
        for (c = 0; c < n; c++) row[c] = draw_value(style);
        if (kind == ROWS_SORTED) begin
          for (c = 1; c < n; c++) begin
            key = row[c];
            j   = c - 1;
            while (j >= 0 && row[j] > key) begin
              row[j + 1] = row[j];
              j--;
            end
            row[j + 1] = key;
          end
        end
        for (c = 0; c < n; c++) send_item(row[c]);
      end
    end
  endtask

  // Receiver: random stalls, stretches with none, and one long hold-off.
  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        gap = HOLD_CYCLES;
      end else begin
        gap = ready_burst ? 0 : $urandom_range(0, 5);
      end
      if ($urandom_range(0, 39) == 0) ready_burst = !ready_burst;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Check every result the moment it is taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_result(sorted_value, last_of_run);
  end

  // Watchdog: restart the count whenever an item moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int           phase, matrices, m, first_random, pick;
    logic [3:0]   code;
    matrix_kind_t kind;
    value_style_t style;
    book          = new();
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    element_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Size one: every item is a whole run of its own; cover both extremes.
    write_matrix_size(4'd1);
    send_item({1'b1, {(srhm_pkg::DATA_W-1){1'b0}}});
    send_item({1'b0, {(srhm_pkg::DATA_W-1){1'b1}}});
    send_item(0);
    send_item(-1);
    // Size zero behaves as size one; alternate every bit of the payload.
    write_matrix_size(4'd0);
    send_item(32'h5555_5555);
    send_item(32'hAAAA_AAAA);
    // Sorted rows holding the most negative and most positive values.
    write_matrix_size(4'd2);
    send_item({1'b1, {(srhm_pkg::DATA_W-1){1'b0}}});
    send_item({1'b0, {(srhm_pkg::DATA_W-1){1'b1}}});
    send_item(-1);
    send_item(0);
    // Unsorted rows with equal heads: the lower row goes first, rows are not re-sorted.
    send_item(7);
    send_item(3);
    send_item(7);
    send_item(-2);
    // Shrink the size mid-load: the next item pushes the count past n*n.
    write_matrix_size(4'd3);
    repeat (4) send_item($urandom);
    write_matrix_size(4'd2);
    send_item($urandom);

    // Random phases: fix a size, then send one to three matrices at it.
    // Phase 2 carries the long receiver stall, phase 4 a full drain between matrices.
    first_random = elements_sent;
    phase = 0;
    while (elements_sent - first_random < RANDOM_ITEMS) begin
      case (phase)
        0:       code = 4'd15;  // saturates to the largest size
        1:       code = 4'd8;
        2:       code = 4'd3;
        4:       code = 4'd2;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6)      code = 4'($urandom_range(0, 4));
          else if (pick < 8) code = 4'($urandom_range(5, 8));
          else               code = 4'($urandom_range(9, 15));
        end
      endcase
      write_matrix_size(code);
      matrices = (phase == 2 || phase == 4) ? 2 : $urandom_range(1, 3);
      for (m = 0; m < matrices; m++) begin
        if (phase == 2 && m == 0) hold_request = 1;
        if (phase == 4 && m == 1) settle();
        pick = $urandom_range(0, 9);
        if (phase == 2 || phase == 4 || pick < 7) kind = ROWS_SORTED;
        else if (pick < 9)                         kind = ROWS_UNSORTED;
        else                                       kind = PARTIAL_LOAD;
        pick = $urandom_range(0, 9);
        if (pick < 5)      style = WIDE;
        else if (pick < 8) style = NARROW;
        else               style = EDGES;
        send_matrix(kind, style);
        if (kind == PARTIAL_LOAD) break;
      end
      phase++;
    end

    // Drain, wait out the tail, then report.
    settle();
    if (book.pending() != 0)
      $display("%0t: %0d results never arrived", $time, book.pending());
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
